@@ rtl/bsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bsf_pkg: shared definitions for the block simhash fingerprint core
// Widths, constants and counter types used by the core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

	// Fingerprint and vote counter geometry.
	localparam int FP_BITS      = 64;
	localparam int COUNTER_BITS = 17;

	// Block size register and fill counter.
	localparam int SIZE_BITS  = 12;
	localparam int LIMIT_BITS = SIZE_BITS + 1;
	localparam logic [LIMIT_BITS-1:0] SIZE_ZERO_LIMIT = LIMIT_BITS'(1) << SIZE_BITS;
	localparam logic [SIZE_BITS-1:0]  SIZE_RESET      = SIZE_BITS'(8);

	// djb2 hash start value.
	localparam logic [FP_BITS-1:0] DJB2_START = FP_BITS'(5381);

	// Configuration port geometry: register index sits above the byte offset.
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = 1;
	localparam int ADDR_BITS     = REG_IDX_BITS + 2;
	localparam logic [REG_IDX_BITS-1:0] REG_BLOCK_SIZE = REG_IDX_BITS'(0);

	// Signed saturating vote counter.
	typedef logic signed [COUNTER_BITS-1:0] cnt_t;
	localparam cnt_t CNT_MAX  = cnt_t'({1'b0, {(COUNTER_BITS-1){1'b1}}});
	localparam cnt_t CNT_MIN  = cnt_t'({1'b1, {(COUNTER_BITS-1){1'b0}}});
	localparam cnt_t CNT_ZERO = cnt_t'(0);
	localparam cnt_t CNT_ONE  = cnt_t'(1);

endpackage

`default_nettype wire

@@ rtl/block_simhash_fingerprint_core.sv @@
// ----------------------------------------------------------------------------
// block_simhash_fingerprint_core: 64-bit simhash over djb2-hashed blocks
// Cuts a byte string into blocks, hashes each block with 64-bit djb2, votes
// the hash bits into saturating counters and emits the sign pattern at the
// end of each string.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  data_byte, byte_present, last
// out       output     out_valid/out_stall  fingerprint
// cfg       input      APB-style, 32 bits   block length at byte address 0
//
// One item per cycle unless the input stalls: an accepted item waits in the
// input register, where the hash update and both possible votes are done.
// A fingerprint is written to the result register at the edge at which its
// end-of-string item leaves the input register. The input stalls only when
// an end-of-string item waits in the input register while the result
// register is full and stalled.
// Reset clears the vote counters, the hash and the fill count at once; no
// clearing pass is needed.
//
`default_nettype none

module block_simhash_fingerprint_core (
	input  wire                                clk,
	input  wire                                arst_n,
	// Input channel
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [7:0]                         data_byte,
	input  wire                                byte_present,
	input  wire                                last,
	// Output channel
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [bsf_pkg::FP_BITS-1:0]        fingerprint,
	// Configuration port
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [bsf_pkg::ADDR_BITS-1:0]      paddr,
	input  wire  [bsf_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [bsf_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);
	import bsf_pkg::*;

	// Saturating step of one vote counter.
	function automatic cnt_t vote_step(input cnt_t cnt, input logic up);
		cnt_t res;
		res = cnt;
		if (up) begin
			if (cnt != CNT_MAX) res = cnt + CNT_ONE;
		end else begin
			if (cnt != CNT_MIN) res = cnt - CNT_ONE;
		end
		return res;
	endfunction

	// Configuration register
	logic [SIZE_BITS-1:0]    blk_len_q;
	logic [REG_IDX_BITS-1:0] reg_idx;

	// Input register
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       byte_present_s1;
	logic       last_s1;

	// String state
	logic [FP_BITS-1:0]   hash_q;
	logic [SIZE_BITS-1:0] fill_q;
	cnt_t                 votes_q [FP_BITS];

	// Result register
	logic               out_valid_q;
	logic [FP_BITS-1:0] fingerprint_q;

	// Working signals
	logic                  out_free;
	logic                  advance;
	logic                  accept;
	logic [LIMIT_BITS-1:0] fill_inc;
	logic [LIMIT_BITS-1:0] limit;
	logic [FP_BITS-1:0]    hash_new;
	logic [FP_BITS-1:0]    hash_after;
	logic [SIZE_BITS-1:0]  fill_after;
	logic                  block_full;
	cnt_t                  votes_one [FP_BITS];
	cnt_t                  votes_two [FP_BITS];
	logic [FP_BITS-1:0]    fp_comb;

	// Configuration port: always ready, one register.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_BLOCK_SIZE: prdata = APB_DATA_BITS'(blk_len_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_BLOCK_SIZE)) begin
			blk_len_q <= pwdata[SIZE_BITS-1:0];
		end
	end

	// Handshake: the input register drains unless an end-of-string item
	// finds the result register full and stalled.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1    <= data_byte;
			byte_present_s1 <= byte_present;
			last_s1         <= last;
		end
	end

	// Hash update and block closing for the item in the input register.
	always_comb begin
		fill_inc = {1'b0, fill_q} + LIMIT_BITS'(1);
		limit    = (blk_len_q == '0) ? SIZE_ZERO_LIMIT : {1'b0, blk_len_q};
		if (byte_present_s1) begin
			hash_new = (hash_q << 5) + hash_q + {{(FP_BITS-8){data_byte_s1[7]}}, data_byte_s1};
		end else begin
			hash_new = hash_q;
		end
		block_full = byte_present_s1 && (fill_inc >= limit);
		hash_after = block_full ? DJB2_START : hash_new;
		if (!byte_present_s1) begin
			fill_after = fill_q;
		end else if (block_full) begin
			fill_after = '0;
		end else begin
			fill_after = fill_inc[SIZE_BITS-1:0];
		end
	end

	// Votes: one for a filled block, one more for the block closed at the
	// end of the string; each counter is handled on its own.
	always_comb begin
		for (int k = 0; k < FP_BITS; k++) begin
			votes_one[k] = block_full ? vote_step(votes_q[k], hash_new[k]) : votes_q[k];
			votes_two[k] = last_s1 ? vote_step(votes_one[k], hash_after[k]) : votes_one[k];
			fp_comb[k]   = !votes_two[k][COUNTER_BITS-1] && (votes_two[k] != CNT_ZERO);
		end
	end

	// String state: cleared after every end of string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= DJB2_START;
			fill_q <= '0;
			for (int k = 0; k < FP_BITS; k++) votes_q[k] <= CNT_ZERO;
		end else if (advance) begin
			if (last_s1) begin
				hash_q <= DJB2_START;
				fill_q <= '0;
				for (int k = 0; k < FP_BITS; k++) votes_q[k] <= CNT_ZERO;
			end else begin
				hash_q <= hash_after;
				fill_q <= fill_after;
				for (int k = 0; k < FP_BITS; k++) votes_q[k] <= votes_one[k];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			fingerprint_q <= fp_comb;
		end
	end

	assign out_valid   = out_valid_q;
	assign fingerprint = fingerprint_q;

endmodule

`default_nettype wire

@@ rtl/bsf_checker.sv @@
// ----------------------------------------------------------------------------
// bsf_checker: port-level checks for the block simhash fingerprint core
// Watches the handshakes and the configuration read path over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_stall,
	input wire                                out_valid,
	input wire                                out_stall,
	input wire [bsf_pkg::FP_BITS-1:0]         fingerprint,
	input wire                                psel,
	input wire                                pwrite,
	input wire [bsf_pkg::ADDR_BITS-1:0]       paddr,
	input wire [bsf_pkg::APB_DATA_BITS-1:0]   prdata,
	input wire                                pready
);
	import bsf_pkg::*;

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(fingerprint))
		else $error("fingerprint changed while stalled");

	// The input only stalls when the result side is full and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled with the result side free");

	// Block size reads back within its width; the port never waits.
	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[ADDR_BITS-1:2] == REG_BLOCK_SIZE)
		|-> pready && (prdata[APB_DATA_BITS-1:SIZE_BITS] == '0))
		else $error("block size read back out of range");

endmodule

bind block_simhash_fingerprint_core bsf_checker u_bsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.fingerprint (fingerprint),
	.psel        (psel),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.prdata      (prdata),
	.pready      (pready)
);

`default_nettype wire
